@@ rtl/core/rscx_pkg.sv @@
package rscx_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // one column of the two row buffers
    typedef struct packed {
        t_rgb older;
        t_rgb newer;
    } t_entry;

    typedef struct packed {
        t_rgb pix;
        logic frame_end;
    } t_res;

    typedef struct packed {
        logic shift;
        logic wrap;
    } t_cell_ctl;

    function automatic logic [7:0] sharpen_chan(
        input logic [7:0] c,
        input logic [7:0] u,
        input logic [7:0] d,
        input logic [7:0] l,
        input logic [7:0] r
    );
        logic        [11:0] c5;
        logic signed [11:0] s;
        logic        [7:0]  q;
        c5 = ({4'b0, c} << 2) + {4'b0, c};
        s  = $signed(c5) - $signed({4'b0, u}) - $signed({4'b0, d})
           - $signed({4'b0, l}) - $signed({4'b0, r});
        if (s < 12'sd0) begin
            q = 8'd0;
        end else if (s > 12'sd255) begin
            q = 8'd255;
        end else begin
            q = s[7:0];
        end
        return q;
    endfunction

    function automatic t_rgb sharpen_px(
        input t_rgb c,
        input t_rgb u,
        input t_rgb d,
        input t_rgb l,
        input t_rgb r
    );
        t_rgb p;
        p.red   = sharpen_chan(c.red,   u.red,   d.red,   l.red,   r.red);
        p.green = sharpen_chan(c.green, u.green, d.green, l.green, r.green);
        p.blue  = sharpen_chan(c.blue,  u.blue,  d.blue,  l.blue,  r.blue);
        return p;
    endfunction

endpackage

@@ rtl/core/rscx_in_if.sv @@
interface rscx_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source(output valid, operation, red_in, green_in, blue_in, input ready);
    modport sink(input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

@@ rtl/core/rscx_out_if.sv @@
interface rscx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source(output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink(input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

@@ rtl/core/rscx_row_mem.sv @@
module rscx_row_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  rscx_pkg::t_entry      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output rscx_pkg::t_entry      o_rdata
);

    rscx_pkg::t_entry r_mem [DEPTH];
    rscx_pkg::t_entry r_rdata;

    // write-first: a read of the address being written returns the new entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= (i_we && (i_waddr == i_raddr)) ? i_wdata : r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rscx_cell.sv @@
module rscx_cell (
    input  logic                  i_clk,
    input  rscx_pkg::t_cell_ctl   i_ctl,
    input  rscx_pkg::t_entry      i_next,
    input  rscx_pkg::t_entry      i_head,
    output rscx_pkg::t_entry      o_q
);

    rscx_pkg::t_entry r_q;

    // shift toward the left neighbor; on row wrap reload the row head
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_q <= i_ctl.wrap ? i_head : i_next;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/core/rgb_sharpen_cross_3x3_top.sv @@
// rgb_sharpen_cross_3x3_top: streaming 3x3 cross sharpening filter for RGB frames.
// Input channel i_pix carries requests: operation 0 is a pixel of the frame in raster
// order, operation 1 drains one pixel of the last row once the frame is complete.
// Interior pixels become 5*centre - up - down - left - right per channel, clamped
// to 0..255; border pixels pass through. Output runs one row behind the input.
// Output channel o_res carries the result pixels; frame_end marks the last one.
// Pixels after frame completion and drains before it are taken and dropped.
// Throughput: one request per cycle while i_pix.ready is high. Each released result
// is queued in a register. The column window is a chain of three cells fed by a
// row memory with a registered read that runs two columns ahead of the request;
// the first two columns of a row are also held in head registers for the wrap.
// A two-entry output queue keeps i_pix.ready high while one result waits, so a
// stalled receiver blocks input only when both entries are full.
// Reset (i_rst_n, synchronous) clears counters, frame state and the queue and sets
// width 640 and height 480. Configuration via i_cfg_we/i_cfg_index/i_cfg_data.
module rgb_sharpen_cross_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rscx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rscx_pkg::CFG_W-1:0]      i_cfg_data,
    rscx_in_if.sink                         i_pix,
    rscx_out_if.source                      o_res
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [rscx_pkg::CFG_W-1:0] r_image_width;
    logic [rscx_pkg::CFG_W-1:0] r_image_height;
    logic [AW-1:0]              r_col;
    logic [AW-1:0]              n_col;
    logic [RW-1:0]              r_row;
    logic                       r_done;
    rscx_pkg::t_entry           r_head0;
    rscx_pkg::t_entry           r_head1;
    rscx_pkg::t_entry           n_head0;
    rscx_pkg::t_entry           n_head1;
    logic [1:0]                 r_cnt;
    rscx_pkg::t_res             r_slot0;
    rscx_pkg::t_res             r_slot1;

    logic [WW-1:0]              eff_w;
    logic [HW-1:0]              eff_h;
    logic                       acc;
    logic                       is_pix;
    logic                       is_drain;
    logic                       last_col;
    logic                       last_row;
    logic                       interior;
    logic                       push;
    logic                       pop;
    rscx_pkg::t_rgb             px;
    rscx_pkg::t_rgb             filt;
    rscx_pkg::t_res             res;
    rscx_pkg::t_entry           wdata;
    rscx_pkg::t_entry           rd_data;
    rscx_pkg::t_entry           q_right;
    rscx_pkg::t_entry           q_centre;
    rscx_pkg::t_entry           q_left;
    rscx_pkg::t_cell_ctl        cell_ctl;
    logic [AW:0]                ra_sum;
    logic [AW-1:0]              raddr;

    always_comb begin
        if (r_image_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_image_height);
        end
    end

    assign acc      = i_pix.valid && i_pix.ready;
    assign is_pix   = acc && (i_pix.operation == rscx_pkg::OP_PIXEL) && !r_done;
    assign is_drain = acc && (i_pix.operation == rscx_pkg::OP_DRAIN) && r_done;
    assign last_col = (WW'(r_col) + WW'(1)) >= eff_w;
    assign last_row = (HW'(r_row) + HW'(1)) >= eff_h;
    assign interior = (r_row >= RW'(2)) && (HW'(r_row) < eff_h) && (r_col != '0) && !last_col;

    assign px.red   = i_pix.red_in;
    assign px.green = i_pix.green_in;
    assign px.blue  = i_pix.blue_in;

    assign filt = rscx_pkg::sharpen_px(q_centre.newer, q_centre.older, px,
                                       q_left.newer, q_right.newer);

    always_comb begin
        if (is_drain) begin
            res.pix       = q_centre.newer;
            res.frame_end = last_col;
        end else begin
            res.pix       = interior ? filt : q_centre.newer;
            res.frame_end = 1'b0;
        end
    end

    assign push = (is_pix && (r_row != '0)) || is_drain;

    assign wdata.older = q_centre.newer;
    assign wdata.newer = px;

    assign n_head0 = (is_pix && (r_col == '0))     ? wdata : r_head0;
    assign n_head1 = (is_pix && (r_col == AW'(1))) ? wdata : r_head1;

    assign cell_ctl.shift = is_pix || is_drain;
    assign cell_ctl.wrap  = last_col;

    assign n_col  = (cell_ctl.shift) ? (last_col ? '0 : r_col + AW'(1)) : r_col;
    assign ra_sum = {1'b0, n_col} + (AW+1)'(2);
    assign raddr  = (ra_sum >= (AW+1)'(MAX_WIDTH)) ? '0 : ra_sum[AW-1:0];

    rscx_row_mem #(
        .DEPTH(MAX_WIDTH),
        .AW   (AW)
    ) u_row_mem (
        .i_clk  (i_clk),
        .i_we   (is_pix),
        .i_waddr(r_col),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd_data)
    );

    rscx_cell u_cell_right (
        .i_clk (i_clk),
        .i_ctl (cell_ctl),
        .i_next(rd_data),
        .i_head(n_head1),
        .o_q   (q_right)
    );

    rscx_cell u_cell_centre (
        .i_clk (i_clk),
        .i_ctl (cell_ctl),
        .i_next(q_right),
        .i_head(n_head0),
        .o_q   (q_centre)
    );

    rscx_cell u_cell_left (
        .i_clk (i_clk),
        .i_ctl (cell_ctl),
        .i_next(q_centre),
        .i_head(q_centre),
        .o_q   (q_left)
    );

    always_ff @(posedge i_clk) begin
        r_head0 <= n_head0;
        r_head1 <= n_head1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rscx_pkg::RST_IMAGE_WIDTH;
            r_image_height <= rscx_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rscx_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                rscx_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_done <= 1'b0;
        end else begin
            r_col <= n_col;
            if (is_pix && last_col) begin
                if (last_row) begin
                    r_done <= 1'b1;
                end else begin
                    r_row <= r_row + RW'(1);
                end
            end else if (is_drain && last_col) begin
                r_row  <= '0;
                r_done <= 1'b0;
            end
        end
    end

    // two-entry result queue
    assign pop         = (r_cnt != 2'd0) && o_res.ready;
    assign i_pix.ready = (r_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_slot0 <= r_slot1;
            end else if (push) begin
                r_slot0 <= res;
            end
        end else if (push && (r_cnt == 2'd0)) begin
            r_slot0 <= res;
        end
        if (push && (r_cnt == 2'd1) && !pop) begin
            r_slot1 <= res;
        end
    end

    assign o_res.valid     = (r_cnt != 2'd0);
    assign o_res.red_out   = r_slot0.pix.red;
    assign o_res.green_out = r_slot0.pix.green;
    assign o_res.blue_out  = r_slot0.pix.blue;
    assign o_res.frame_end = r_slot0.frame_end;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_no_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && i_pix.valid && i_pix.ready && i_pix.operation == rscx_pkg::OP_PIXEL)
        |=> $stable(r_col))
        else $error("pixel changed column state after frame completion");

    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_res.valid)
        else $error("result request lost");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && res.frame_end) |=> (!r_done && r_col == '0 && r_row == '0))
        else $error("frame state not cleared after last drain");

endmodule
